/* design/kmp_pkg.sv */
// kmp_pkg: shared types and helper of the streaming knuth-morris-pratt matcher
// command and result transaction structs, command and kind codes, controller states
// no dependencies
`default_nettype none

package kmp_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } kmp_cmd_t;

    typedef enum logic {
        KIND_MATCH   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kmp_kind_t;

    typedef struct packed {
        kmp_cmd_t    cmd;
        logic [7:0]  symbol;
    } kmp_in_t;

    typedef struct packed {
        kmp_kind_t   kind;
        logic [15:0] match_start;
        logic [31:0] comparisons;
    } kmp_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } kmp_state_t;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    function automatic logic [31:0] sat_add(input logic [31:0] total, input logic [1:0] inc);
        logic [32:0] sum;
        sum = {1'b0, total} + {31'd0, inc};
        if (sum[32])
            return COUNT_MAX;
        return sum[31:0];
    endfunction

endpackage

`default_nettype wire

/* design/kmp_stream_matcher.sv */
// kmp_stream_matcher: knuth-morris-pratt matcher over 8-bit symbols, pattern built online
// depends on kmp_pkg and kmp_ram (pattern store and failure table)
//
// usage: commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd_item), results leave
// on the res channel (res_valid, res_stall, res_item). clear empties the pattern and run
// counters, append adds a pattern symbol, text feeds one symbol, end emits the summary.
// a text symbol gives a match transaction when the whole pattern has matched; end gives a
// summary transaction with the comparison count and restarts the run counters.
// clear and end are handled in the idle state, as are a text symbol on an empty pattern
// and the first append. otherwise append and text go through the walk state, with one
// read of the pattern and failure memories (registered read data) per failure-link
// fallback; fallbacks amortize to under one per text symbol. cmd_stall is high while a
// symbol is being walked or a result waits to load.
// the result sits in an output register; a new command is taken while it waits, and the
// block only holds when a second result is ready and res_stall still blocks the first.
// reset: asynchronous, clears pattern length, run counters and the output valid; memory
// contents are not cleared and are only read below the current pattern length.
`default_nettype none

module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX = 256,
    parameter longint unsigned TEXT_MAX = 65536
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output      logic     cmd_stall,
    input  wire kmp_in_t  cmd_item,
    output      logic     res_valid,
    input  wire logic     res_stall,
    output      kmp_out_t res_item
);

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int ADDR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int IDX_W  = $clog2(TEXT_MAX + 1);
    localparam int SW     = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(TEXT_MAX);

    kmp_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  build_reg, build_next;
    logic [LEN_W-1:0]  matched_reg, matched_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       total_reg, total_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  walk_reg, walk_next;
    logic [7:0]        sym_reg, sym_next;
    logic              text_mode_reg, text_mode_next;
    kmp_out_t          res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    kmp_out_t          out_data_reg, out_data_next;

    logic              accept;
    logic              out_free;
    logic              load_out;
    kmp_out_t          load_data;
    logic              pat_we;
    logic              fail_we;
    logic [LEN_W-1:0]  rd_q;
    logic [LEN_W-1:0]  rd_qm1;
    logic [7:0]        pat_rd;
    logic [ADDR_W-1:0] fail_rd;
    logic [LEN_W-1:0]  q_init;
    logic [LEN_W-1:0]  q_fin;
    logic [IDX_W-1:0]  idx_inc;
    logic [SW-1:0]     start_diff;
    logic [15:0]       start_pos;

    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res_item  = out_data_reg;
    assign rd_qm1    = rd_q - LEN_W'(1);

    kmp_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_MAX)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (cmd_item.symbol),
        .raddr (rd_q[ADDR_W-1:0]),
        .rdata (pat_rd)
    );

    kmp_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (PATTERN_MAX)
    ) u_failure_ram (
        .clk   (clk),
        .we    (fail_we),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (q_fin[ADDR_W-1:0]),
        .raddr (rd_qm1[ADDR_W-1:0]),
        .rdata (fail_rd)
    );

    // next text index and match start position
    always_comb
    begin
        if (idx_reg < IDX_LIMIT)
            idx_inc = idx_reg + IDX_W'(1);
        else
            idx_inc = idx_reg;
        start_diff = SW'(idx_reg) + SW'(1) - SW'(len_reg);
        if (idx_reg >= IDX_LIMIT)
            start_pos = 16'hFFFF;
        else if ((SW'(idx_reg) + SW'(1)) < SW'(len_reg))
            start_pos = 16'd0;
        else if (start_diff > 65535)
            start_pos = 16'hFFFF;
        else
            start_pos = 16'(start_diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            build_reg     <= '0;
            matched_reg   <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            build_reg     <= build_next;
            matched_reg   <= matched_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        sym_reg       <= sym_next;
        text_mode_reg <= text_mode_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        build_next     = build_reg;
        matched_next   = matched_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        pend_next      = pend_reg;
        walk_next      = walk_reg;
        sym_next       = sym_reg;
        text_mode_next = text_mode_reg;
        res_next       = res_reg;
        load_out       = 1'b0;
        load_data      = res_reg;
        pat_we         = 1'b0;
        fail_we        = 1'b0;
        rd_q           = walk_reg;
        q_init         = '0;
        q_fin          = (pat_rd == sym_reg) ? walk_reg + LEN_W'(1) : walk_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_item.cmd)
                        CMD_CLEAR:
                        begin
                            len_next     = '0;
                            build_next   = '0;
                            matched_next = '0;
                            idx_next     = '0;
                            total_next   = '0;
                            pend_next    = 1'b0;
                        end
                        CMD_APPEND:
                        begin
                            if (len_reg < LEN_W'(PATTERN_MAX))
                            begin
                                pat_we = 1'b1;
                                if (len_reg == '0)
                                begin
                                    fail_we    = 1'b1;
                                    q_fin      = '0;
                                    build_next = '0;
                                    len_next   = LEN_W'(1);
                                end
                                else
                                begin
                                    q_init         = (build_reg >= len_reg) ? '0 : build_reg;
                                    rd_q           = q_init;
                                    walk_next      = q_init;
                                    sym_next       = cmd_item.symbol;
                                    text_mode_next = 1'b0;
                                    state_next     = ST_WALK;
                                end
                            end
                        end
                        CMD_TEXT:
                        begin
                            total_next = sat_add(total_reg, {pend_reg, ~pend_reg});
                            pend_next  = 1'b0;
                            if (len_reg == '0)
                            begin
                                idx_next = idx_inc;
                            end
                            else
                            begin
                                q_init         = (matched_reg >= len_reg) ? '0 : matched_reg;
                                rd_q           = q_init;
                                walk_next      = q_init;
                                sym_next       = cmd_item.symbol;
                                text_mode_next = 1'b1;
                                state_next     = ST_WALK;
                            end
                        end
                        CMD_END:
                        begin
                            load_data.kind        = KIND_SUMMARY;
                            load_data.match_start = '0;
                            load_data.comparisons = total_reg;
                            res_next              = load_data;
                            matched_next          = '0;
                            idx_next              = '0;
                            total_next            = '0;
                            pend_next             = 1'b0;
                            if (out_free)
                                load_out = 1'b1;
                            else
                                state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if ((walk_reg != '0) && (pat_rd != sym_reg))
                begin
                    // fall back along the failure link
                    rd_q      = LEN_W'(fail_rd);
                    walk_next = LEN_W'(fail_rd);
                    if (text_mode_reg)
                        total_next = sat_add(total_reg, 2'd1);
                end
                else if (text_mode_reg)
                begin
                    idx_next   = idx_inc;
                    state_next = ST_IDLE;
                    if (q_fin == len_reg)
                    begin
                        load_data.kind        = KIND_MATCH;
                        load_data.match_start = start_pos;
                        load_data.comparisons = total_reg;
                        res_next              = load_data;
                        matched_next          = build_reg;
                        pend_next             = 1'b1;
                        if (out_free)
                            load_out = 1'b1;
                        else
                            state_next = ST_EMIT;
                    end
                    else
                    begin
                        matched_next = q_fin;
                    end
                end
                else
                begin
                    fail_we    = 1'b1;
                    build_next = q_fin;
                    len_next   = len_reg + LEN_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && res_stall;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = load_data;
        end
    end

endmodule

`default_nettype wire

/* design/kmp_ram.sv */
// kmp_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
